/* sv/text_terminal_screen_writer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the text terminal screen writer
// Shared concurrent-check helpers, clocked on rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_SCREEN_WRITER_UNIT_MACROS_SVH
`define TEXT_TERMINAL_SCREEN_WRITER_UNIT_MACROS_SVH

// same-cycle implication
`define TTSW_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTSW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ttsw_pkg.sv */
// ----------------------------------------------------------------------------
// ttsw_pkg
// Geometry, character codes, types and address helpers for the screen writer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttsw_pkg;

    localparam int WIDTH  = 80;
    localparam int HEIGHT = 25;
    localparam int CELLS  = WIDTH * HEIGHT;

    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_BLANK
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } mem_wr_t;

    // logical row -> physical row of the circular row store
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (ROW_W+1)'(HEIGHT))
            sum = sum - (ROW_W+1)'(HEIGHT);
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(WIDTH) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

/* sv/ttsw_if.sv */
// ----------------------------------------------------------------------------
// ttsw_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttsw_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [ttsw_pkg::CHAR_W-1:0]   char_code;
    logic [ttsw_pkg::ROW_W-1:0]    read_row;
    logic [ttsw_pkg::COL_W-1:0]    read_col;

    modport source (output valid, command, char_code, read_row, read_col, input ready);
    modport sink   (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface ttsw_out_if;
    logic                          valid;
    logic                          ready;
    logic [ttsw_pkg::CHAR_W-1:0]   cell_char;
    logic [ttsw_pkg::COL_W-1:0]    cursor_col;
    logic [ttsw_pkg::ROW_W-1:0]    cursor_row;

    modport source (output valid, cell_char, cursor_col, cursor_row, input ready);
    modport sink   (input valid, cell_char, cursor_col, cursor_row, output ready);
endinterface

`default_nettype wire

/* sv/ttsw_screen_mem.sv */
// ----------------------------------------------------------------------------
// ttsw_screen_mem
// Screen character store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ttsw_screen_mem (
    input  wire logic                        clk,
    input  wire ttsw_pkg::mem_wr_t           wr,
    input  wire logic [ttsw_pkg::ADDR_W-1:0] raddr,
    output logic      [ttsw_pkg::CHAR_W-1:0] rdata
);
    import ttsw_pkg::*;

    logic [CHAR_W-1:0] screen_mem [CELLS];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            screen_mem[wr.addr] <= wr.data;
        end
        rdata_reg <= screen_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/ttsw_ctrl.sv */
// ----------------------------------------------------------------------------
// ttsw_ctrl
// Cursor, scroll pointer, clear/blank sweeps and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttsw_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    ttsw_in_if.sink                          item,
    ttsw_out_if.source                       result,
    output ttsw_pkg::mem_wr_t                mem_wr,
    output logic      [ttsw_pkg::ADDR_W-1:0] mem_raddr,
    input  wire logic [ttsw_pkg::CHAR_W-1:0] mem_rdata
);
    import ttsw_pkg::*;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [COL_W-1:0]  blank_cnt_reg, blank_cnt_next;
    logic [COL_W-1:0]  cur_x_reg, cur_x_next;
    logic [ROW_W-1:0]  cur_y_reg, cur_y_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;

    logic              accept;
    logic              rd_ok;
    logic [COL_W-1:0]  nx;
    logic [ROW_W:0]    ny;
    logic [COL_W-1:0]  x_inc;

    assign item.ready = (state_reg == ST_IDLE) && (!out_valid_reg || result.ready);
    assign accept     = item.valid && item.ready;
    assign x_inc      = cur_x_reg + COL_W'(1);
    assign rd_ok      = (item.read_row < ROW_W'(HEIGHT)) && (item.read_col < COL_W'(WIDTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sweep_addr_reg <= '0;
            blank_cnt_reg  <= '0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            top_reg        <= '0;
            rd_ok_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            blank_cnt_reg  <= blank_cnt_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            top_reg        <= top_next;
            rd_ok_reg      <= rd_ok_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        blank_cnt_next  = blank_cnt_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        top_next        = top_reg;
        rd_ok_next      = rd_ok_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_char_next   = out_char_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        mem_wr          = '0;
        mem_raddr       = '0;
        nx              = cur_x_reg;
        ny              = {1'b0, cur_y_reg};

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr.en       = 1'b1;
                mem_wr.addr     = sweep_addr_reg;
                mem_wr.data     = CH_NUL;
                sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                if (sweep_addr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == CMD_READ)
                    begin
                        rd_ok_next = rd_ok;
                        mem_raddr  = rd_ok ? cell_addr(phys_row(item.read_row, top_reg),
                                                       item.read_col) : '0;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        unique case (item.char_code)
                            CH_NUL: ;
                            CH_CR:  nx = '0;
                            CH_LF:  ny = {1'b0, cur_y_reg} + (ROW_W+1)'(1);
                            CH_BS:
                            begin
                                if (cur_x_reg != '0)
                                    nx = cur_x_reg - COL_W'(1);
                            end
                            default:
                            begin
                                mem_wr.en   = 1'b1;
                                mem_wr.addr = cell_addr(phys_row(cur_y_reg, top_reg),
                                                        cur_x_reg);
                                mem_wr.data = item.char_code;
                                if (x_inc == COL_W'(WIDTH))
                                begin
                                    nx = '0;
                                    ny = {1'b0, cur_y_reg} + (ROW_W+1)'(1);
                                end
                                else
                                begin
                                    nx = x_inc;
                                end
                            end
                        endcase

                        // cursor fell off the bottom: rotate rows, blank old top
                        if (ny == (ROW_W+1)'(HEIGHT))
                        begin
                            ny              = (ROW_W+1)'(HEIGHT - 1);
                            top_next        = (top_reg == ROW_W'(HEIGHT - 1)) ? '0
                                                                              : top_reg + ROW_W'(1);
                            sweep_addr_next = cell_addr(top_reg, '0);
                            blank_cnt_next  = '0;
                            state_next      = ST_BLANK;
                        end

                        cur_x_next     = nx;
                        cur_y_next     = ny[ROW_W-1:0];
                        out_valid_next = 1'b1;
                        out_char_next  = '0;
                        out_col_next   = nx;
                        out_row_next   = ny[ROW_W-1:0];
                    end
                end
            end

            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_char_next  = rd_ok_reg ? mem_rdata : '0;
                out_col_next   = cur_x_reg;
                out_row_next   = cur_y_reg;
                state_next     = ST_IDLE;
            end

            ST_BLANK:
            begin
                mem_wr.en       = 1'b1;
                mem_wr.addr     = sweep_addr_reg;
                mem_wr.data     = CH_SPACE;
                sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                blank_cnt_next  = blank_cnt_reg + COL_W'(1);
                if (blank_cnt_reg == COL_W'(WIDTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result.valid      = out_valid_reg;
    assign result.cell_char  = out_char_reg;
    assign result.cursor_col = out_col_reg;
    assign result.cursor_row = out_row_reg;

endmodule

`default_nettype wire

/* sv/text_terminal_screen_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_terminal_screen_writer_unit
// A write's result goes straight into the result register; a read's result passes the RAM
// read register first. Writes go one per cycle while the result is not stalled; a read holds
// off the next item until its data is out (single read port). A write that scrolls holds the
// input not ready while the old top row is blanked. Reset: cursor and row pointer clear at
// once; a pass over all WIDTH*HEIGHT (2000) cells then zeroes the RAM, input held not ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_terminal_screen_writer_unit_macros.svh"

module text_terminal_screen_writer_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ttsw_in_if.sink    item,
    ttsw_out_if.source result
);
    import ttsw_pkg::*;

    // Screen rows live in a circular store: a row pointer names the physical
    // row shown on top, so a scroll is a pointer bump plus one row of blanking
    // instead of moving the whole screen.
    mem_wr_t           mem_wr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;

    // Controller: cursor, row pointer, sweeps and the result register.
    ttsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .mem_wr    (mem_wr),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Character RAM, one byte per cell.
    ttsw_screen_mem u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // A write transaction always yields its result on the next cycle.
    `TTSW_ASSERT_NEXT(a_write_result, clk, rst_n,
        item.valid && item.ready && (item.command == CMD_WRITE),
        result.valid && (result.cell_char == CH_NUL),
        "write transaction did not produce a zero-char result")

    // A read occupies the RAM port; no new transaction in the following cycle.
    `TTSW_ASSERT_NEXT(a_read_busy, clk, rst_n,
        item.valid && item.ready && (item.command == CMD_READ),
        !item.ready,
        "transaction accepted while a read was in flight")

    // Reported cursor is always on screen.
    `TTSW_ASSERT_NOW(a_cursor_range, clk, rst_n,
        result.valid,
        (result.cursor_row < ROW_W'(HEIGHT)) && (result.cursor_col < COL_W'(WIDTH)),
        "cursor outside the screen")

    // The RAM is never written while the input side is open for a new transaction
    // unless that write belongs to the transaction being accepted.
    `TTSW_ASSERT_NOW(a_write_owner, clk, rst_n,
        mem_wr.en && item.ready,
        item.valid && (item.command == CMD_WRITE),
        "RAM write with no owning transaction")

endmodule

`default_nettype wire

/* dv/ttsw_screen_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttsw_screen_checker
// Watches both channels and keeps a shadow of the screen and cursor. Each
// accepted command transaction queues the result it should produce. Each
// accepted result transaction is compared with the oldest queued result.
// ----------------------------------------------------------------------------

module ttsw_screen_checker
    import ttsw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ttsw_in_if          item,
    ttsw_out_if         result,
    output int unsigned mismatches,
    output int unsigned outstanding
);

    // print cap keeps a badly broken design from flooding the log
    localparam int unsigned PRINT_CAP = 200;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } screen_view_t;

    logic [CHAR_W-1:0] screen_shadow [HEIGHT][WIDTH];
    logic [COL_W-1:0]  shadow_col;
    logic [ROW_W-1:0]  shadow_row;
    screen_view_t      pending_views [$];
    int unsigned       results_seen;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
                     $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // apply one command to the shadow screen and return what the block reports
    function automatic screen_view_t apply_command(input logic              cmd,
                                                   input logic [CHAR_W-1:0] code,
                                                   input logic [ROW_W-1:0]  row,
                                                   input logic [COL_W-1:0]  col);
        screen_view_t view;
        view.cell_char = '0;
        if (cmd == CMD_WRITE) begin
            if (code == CH_NUL) begin
                // dropped
            end else if (code == CH_CR) begin
                shadow_col = '0;
            end else if (code == CH_LF) begin
                shadow_row = shadow_row + 1'b1;
            end else if (code == CH_BS) begin
                if (shadow_col != 0)
                    shadow_col = shadow_col - 1'b1;
            end else begin
                screen_shadow[shadow_row][shadow_col] = code;
                shadow_col = shadow_col + 1'b1;
                if (shadow_col >= WIDTH) begin
                    shadow_col = '0;
                    shadow_row = shadow_row + 1'b1;
                end
            end
            // scroll up one row, blank the bottom
            if (shadow_row >= HEIGHT) begin
                for (int r = 0; r < HEIGHT - 1; r++)
                    screen_shadow[r] = screen_shadow[r + 1];
                for (int c = 0; c < WIDTH; c++)
                    screen_shadow[HEIGHT-1][c] = CH_SPACE;
                shadow_row = ROW_W'(HEIGHT - 1);
            end
        end else if (row < HEIGHT && col < WIDTH) begin
            view.cell_char = screen_shadow[row][col];
        end
        view.cursor_col = shadow_col;
        view.cursor_row = shadow_row;
        return view;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        screen_view_t want;
        if (!rst_n) begin
            for (int r = 0; r < HEIGHT; r++)
                for (int c = 0; c < WIDTH; c++)
                    screen_shadow[r][c] = '0;
            shadow_col = '0;
            shadow_row = '0;
            pending_views.delete();
            results_seen = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            if (item.valid && item.ready)
                pending_views.insert(pending_views.size(),
                                     apply_command(item.command, item.char_code,
                                                   item.read_row, item.read_col));
            if (result.valid && result.ready) begin
                if (pending_views.size() == 0) begin
                    report_mismatch("unexpected result, cursor_col", result.cursor_col, 0);
                end else begin
                    want = pending_views.pop_front();
                    if (result.cell_char !== want.cell_char)
                        report_mismatch("cell_char", result.cell_char, want.cell_char);
                    if (result.cursor_col !== want.cursor_col)
                        report_mismatch("cursor_col", result.cursor_col, want.cursor_col);
                    if (result.cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", result.cursor_row, want.cursor_row);
                end
                results_seen++;
            end
            outstanding <= pending_views.size();
        end
    end

endmodule

/* dv/tb_text_terminal_screen_writer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_terminal_screen_writer_unit
// Drives write and read commands into the screen writer with bursty valid and
// a patterned result ready. A short directed sequence hits the field extremes
// and the control bytes, then random terminal traffic exercises wrapping,
// scrolling and out-of-range reads. The checker beside the block does all
// prediction; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------

module tb_text_terminal_screen_writer_unit;
    import ttsw_pkg::*;

    localparam int          RANDOM_ITEMS = 1530;
    // clearing pass covers all 2000 cells; a scroll holds input while a row is blanked
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    // give a little slack after the last result
    localparam int          DRAIN_CYCLES = 16;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned cycle_count = 0;

    // sender burst state and receiver stall pattern state
    int unsigned burst_left;
    int unsigned stretch_left;
    int unsigned stall_mode;

    ttsw_in_if  item_if ();
    ttsw_out_if result_if ();

    text_terminal_screen_writer_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    ttsw_screen_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_if),
        .result      (result_if),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: stretches of random length, each in one mode - always ready,
    // coin-flip ready, or mostly stalled (ready with a one-in-four chance).
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            stretch_left    <= 0;
            stall_mode      <= 0;
        end
        else
        begin
            if (stretch_left == 0)
            begin
                stall_mode   <= $urandom_range(0, 2);
                stretch_left <= $urandom_range(8, 64);
            end
            else
            begin
                stretch_left <= stretch_left - 1;
            end
            case (stall_mode)
                0:       result_if.ready <= 1'b1;
                1:       result_if.ready <= 1'($urandom_range(0, 1));
                default: result_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog: a stuck handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("text_terminal_screen_writer_unit verification failed");
            $finish;
        end
    end

    // One command transaction. Between bursts the sender drops valid for a
    // random gap, usually short, sometimes long. Valid is raised only in a
    // later step than the one that lowered it.
    task automatic send_command(input logic              cmd,
                                input logic [CHAR_W-1:0] code,
                                input logic [ROW_W-1:0]  row,
                                input logic [COL_W-1:0]  col);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 3);
            if (gap != 0)
            begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        item_if.valid     <= 1'b1;
        item_if.command   <= cmd;
        item_if.char_code <= code;
        item_if.read_row  <= row;
        item_if.read_col  <= col;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
    endtask

    // Write with random junk in the read address fields, which must be ignored.
    task automatic type_char(input logic [CHAR_W-1:0] code);
        send_command(CMD_WRITE, code, ROW_W'($urandom), COL_W'($urandom));
    endtask

    // Read with random junk in char_code.
    task automatic get_cell(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        send_command(CMD_READ, CHAR_W'($urandom), row, col);
    endtask

    initial
    begin
        int unsigned        pick;
        int unsigned        kind;
        logic [CHAR_W-1:0]  code;

        rst_n             = 1'b0;
        burst_left        = 0;
        item_if.valid     = 1'b0;
        item_if.command   = CMD_WRITE;
        item_if.char_code = '0;
        item_if.read_row  = '0;
        item_if.read_col  = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // fresh screen reads zero, corners and every kind of out-of-range read
        get_cell('0, '0);
        get_cell(ROW_W'(HEIGHT - 1), COL_W'(WIDTH - 1));
        get_cell('1, '1);
        get_cell(ROW_W'(HEIGHT - 1), COL_W'(WIDTH));
        get_cell(ROW_W'(HEIGHT), '0);
        // backspace at column zero stays put, NUL is dropped
        type_char(CH_BS);
        type_char(CH_NUL);
        // printable, top of the byte range, high half, a non-special control
        type_char(8'h41);
        type_char(8'hFF);
        type_char(8'h80);
        type_char(8'h01);
        // backspace, carriage return, line feed, then a char on the next row
        type_char(CH_BS);
        type_char(CH_CR);
        type_char(CH_LF);
        type_char(8'h7E);
        // read back what was written; the cursor must not move on reads
        get_cell(ROW_W'(0), COL_W'(0));
        get_cell(ROW_W'(0), COL_W'(1));
        get_cell(ROW_W'(0), COL_W'(2));
        get_cell(ROW_W'(0), COL_W'(3));
        get_cell(ROW_W'(1), COL_W'(0));
        get_cell(ROW_W'(1), COL_W'(1));

        // --- random terminal traffic ---
        // Mostly writes so the cursor wraps and the screen scrolls many times;
        // line feeds are frequent enough to keep scrolling on the last row.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 22)
            begin
                get_cell(ROW_W'($urandom_range(0, HEIGHT - 1)),
                         COL_W'($urandom_range(0, WIDTH - 1)));
            end
            else if (pick < 28)
            begin
                // full field range, mostly off-screen
                get_cell(ROW_W'($urandom), COL_W'($urandom));
            end
            else
            begin
                kind = $urandom_range(0, 99);
                if (kind < 12)
                    code = CH_LF;
                else if (kind < 20)
                    code = CH_CR;
                else if (kind < 28)
                    code = CH_BS;
                else if (kind < 31)
                    code = CH_NUL;
                else if (kind < 41)
                    code = CHAR_W'($urandom_range(128, 255));
                else if (kind < 45)
                    code = CHAR_W'($urandom_range(1, 31));
                else
                    code = CHAR_W'($urandom_range(32, 126));
                type_char(code);
            end
        end
        item_if.valid <= 1'b0;

        // let the checker count the last transaction, then wait for every
        // queued result and let any stray one show up
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if ((mismatches == 0) && (outstanding == 0))
            $display("text_terminal_screen_writer_unit verification clean");
        else
            $display("text_terminal_screen_writer_unit verification failed");
        $finish;
    end

endmodule
